[rtl/signed_distance_cell_vote_map_top_macros.svh]
// Assertion macros for the top file of the cell vote map.
`ifndef SIGNED_DISTANCE_CELL_VOTE_MAP_TOP_MACROS_SVH
`define SIGNED_DISTANCE_CELL_VOTE_MAP_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDCVM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDCVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sdcvm_pkg.sv]
package sdcvm_pkg;

   localparam int MAX_COLS   = 64;
   localparam int MAX_ROWS   = 64;
   localparam int COL_BITS   = $clog2(MAX_COLS);
   localparam int ROW_BITS   = $clog2(MAX_ROWS);
   localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;

   localparam int OP_BITS    = 2;
   localparam int DIST_BITS  = 24;
   localparam int COORD_BITS = 17;
   localparam int FRAC_BITS  = 16;
   localparam int CNT_BITS   = 16;
   localparam int SIZE_BITS  = 7;
   localparam int CELL_BITS  = 6;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = SIZE_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_HEIGHT = 1'b1;

   localparam logic [SIZE_BITS-1:0]  SIZE_RESET = SIZE_BITS'(64);
   localparam logic [SIZE_BITS-1:0]  COLS_TOP   = SIZE_BITS'(MAX_COLS);
   localparam logic [SIZE_BITS-1:0]  ROWS_TOP   = SIZE_BITS'(MAX_ROWS);
   localparam logic [COORD_BITS-1:0] COORD_ONE  = COORD_BITS'(65536);

   localparam logic signed [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};
   localparam logic signed [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
   localparam logic [CNT_BITS-1:0]         CNT_MAX  = {CNT_BITS{1'b1}};

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_FETCH,
      ST_UPDATE
   } back_state_type;

   typedef struct packed {
      op_type                       op;
      logic [ADDR_BITS-1:0]         addr;
      logic signed [DIST_BITS-1:0]  distance;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic [CNT_BITS-1:0]          pos_cnt;
      logic [CNT_BITS-1:0]          neg_cnt;
      logic signed [DIST_BITS-1:0]  max_dist;
      logic signed [DIST_BITS-1:0]  min_dist;
   } cell_word_type;

   localparam cell_word_type CLEAR_WORD = '{
      pos_cnt:  '0,
      neg_cnt:  '0,
      max_dist: DIST_MIN,
      min_dist: DIST_MAX
   };

   // A size of zero counts as one; anything above the grid counts as the grid.
   function automatic logic [SIZE_BITS-1:0] clamp_size(
      input logic [SIZE_BITS-1:0] v,
      input logic [SIZE_BITS-1:0] top
   );
      logic [SIZE_BITS-1:0] r;
      if (v == '0) begin
         r = SIZE_BITS'(1);
      end else if (v > top) begin
         r = top;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // floor(coord * size / 1.0) with the coordinate held to 1.0 and the top
   // bin folded onto the last one.
   function automatic logic [CELL_BITS-1:0] bin_of(
      input logic [COORD_BITS-1:0] coord,
      input logic [SIZE_BITS-1:0]  size
   );
      logic [COORD_BITS-1:0]           c;
      logic [COORD_BITS+SIZE_BITS-1:0] prod;
      logic [SIZE_BITS:0]              b;
      c    = (coord > COORD_ONE) ? COORD_ONE : coord;
      prod = (COORD_BITS+SIZE_BITS)'(c) * (COORD_BITS+SIZE_BITS)'(size);
      b    = prod[COORD_BITS+SIZE_BITS-1:FRAC_BITS];
      if (b >= {1'b0, size}) begin
         b = {1'b0, size} - (SIZE_BITS+1)'(1);
      end
      return b[CELL_BITS-1:0];
   endfunction

endpackage

[rtl/sdcvm_if.sv]
interface sdcvm_req_if import sdcvm_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [OP_BITS-1:0]           opcode;
   logic signed [DIST_BITS-1:0]  distance;
   logic [COORD_BITS-1:0]        coord_u;
   logic [COORD_BITS-1:0]        coord_v;
   logic [CELL_BITS-1:0]         cell_col;
   logic [CELL_BITS-1:0]         cell_row;

   modport source (output valid, opcode, distance, coord_u, coord_v, cell_col, cell_row,
                   input ready);
   modport sink   (input valid, opcode, distance, coord_u, coord_v, cell_col, cell_row,
                   output ready);
endinterface

interface sdcvm_rsp_if import sdcvm_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         cell_empty;
   logic signed [DIST_BITS-1:0]  height_value;
   logic [CNT_BITS-1:0]          positive_count;
   logic [CNT_BITS-1:0]          negative_count;

   modport source (output valid, cell_empty, height_value, positive_count, negative_count,
                   input ready);
   modport sink   (input valid, cell_empty, height_value, positive_count, negative_count,
                   output ready);
endinterface

[rtl/sdcvm_front.sv]
module sdcvm_front import sdcvm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   sdcvm_req_if.sink                  req,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                       clearing,
   input  queue_status_type           q_stat,
   output logic                       push,
   output entry_type                  push_entry
);

   // Grid sizes are held already clamped to the legal range.
   logic [SIZE_BITS-1:0] width_ff,  width_in;
   logic [SIZE_BITS-1:0] height_ff, height_in;
   logic                 accept;
   logic [CELL_BITS-1:0] bin_col;
   logic [CELL_BITS-1:0] bin_row;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  width_in  = clamp_size(csr_wdata, COLS_TOP);
            CSR_MAP_HEIGHT: height_in = clamp_size(csr_wdata, ROWS_TOP);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign req.ready = !q_stat.full && !clearing;
   assign accept    = req.valid && req.ready;
   assign bin_col   = bin_of(req.coord_u, width_ff);
   assign bin_row   = bin_of(req.coord_v, height_ff);

   // The cell fields are as wide as the grid, so every named cell is inside it.
   always_comb begin
      push                = 1'b0;
      push_entry.op       = OP_ADD;
      push_entry.addr     = {req.cell_row, req.cell_col};
      push_entry.distance = req.distance;
      unique case (req.opcode)
         OP_ADD: begin
            push            = accept;
            push_entry.op   = OP_ADD;
            push_entry.addr = {bin_row, bin_col};
         end
         OP_READ: begin
            push          = accept;
            push_entry.op = OP_READ;
         end
         OP_CLEAR: begin
            push          = accept;
            push_entry.op = OP_CLEAR;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

[rtl/sdcvm_queue.sv]
module sdcvm_queue import sdcvm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  entry_type         push_entry,
   input  logic              pop,
   output entry_type         head,
   output queue_status_type  q_stat
);

   entry_type             slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff,  count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = slots_ff[rd_ptr_ff];
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));

endmodule

[rtl/sdcvm_back.sv]
module sdcvm_back import sdcvm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  entry_type         head,
   input  queue_status_type  q_stat,
   output logic              pop,
   output logic              clearing,
   sdcvm_rsp_if.source       rsp
);

   cell_word_type         mem [CELL_COUNT];
   cell_word_type         rd_word_ff;
   back_state_type        state_ff,    state_in;
   logic [ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   entry_type             cur_ff,      cur_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         empty_ff,     empty_in;
   logic signed [DIST_BITS-1:0]  value_ff,     value_in;
   logic [CNT_BITS-1:0]          pcnt_ff,      pcnt_in;
   logic [CNT_BITS-1:0]          ncnt_ff,      ncnt_in;

   logic                  rd_en;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   cell_word_type         wr_data;
   cell_word_type         upd_word;
   logic                  out_free;
   logic                  load;
   logic                  is_neg;
   logic                  rd_empty;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign is_neg   = cur_ff.distance[DIST_BITS-1];
   assign rd_empty = (rd_word_ff.pos_cnt == '0) && (rd_word_ff.neg_cnt == '0);

   always_comb begin
      upd_word = rd_word_ff;
      if (is_neg) begin
         if (rd_word_ff.neg_cnt != CNT_MAX) begin
            upd_word.neg_cnt = rd_word_ff.neg_cnt + CNT_BITS'(1);
         end
      end else if (rd_word_ff.pos_cnt != CNT_MAX) begin
         upd_word.pos_cnt = rd_word_ff.pos_cnt + CNT_BITS'(1);
      end
      if (cur_ff.distance > rd_word_ff.max_dist) begin
         upd_word.max_dist = cur_ff.distance;
      end
      if (cur_ff.distance < rd_word_ff.min_dist) begin
         upd_word.min_dist = cur_ff.distance;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      cur_in      = cur_ff;
      pop         = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = cur_ff.addr;
      wr_data     = upd_word;
      load        = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = CLEAR_WORD;
            clr_addr_in = clr_addr_ff + ADDR_BITS'(1);
            if (clr_addr_ff == ADDR_BITS'(CELL_COUNT - 1)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               cur_in   = head;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            unique case (cur_ff.op)
               OP_ADD: begin
                  wr_en    = 1'b1;
                  state_in = ST_FETCH;
               end
               OP_CLEAR: begin
                  wr_en    = 1'b1;
                  wr_data  = CLEAR_WORD;
                  state_in = ST_FETCH;
               end
               OP_READ: begin
                  if (out_free) begin
                     load     = 1'b1;
                     state_in = ST_FETCH;
                  end
               end
               default: begin
                  state_in = ST_FETCH;
               end
            endcase
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      empty_in     = empty_ff;
      value_in     = value_ff;
      pcnt_in      = pcnt_ff;
      ncnt_in      = ncnt_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         empty_in     = rd_empty;
         pcnt_in      = rd_word_ff.pos_cnt;
         ncnt_in      = rd_word_ff.neg_cnt;
         if (rd_empty) begin
            value_in = '0;
         end else if (rd_word_ff.pos_cnt > rd_word_ff.neg_cnt) begin
            value_in = rd_word_ff.max_dist;
         end else begin
            value_in = rd_word_ff.min_dist;
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      empty_ff <= empty_in;
      value_ff <= value_in;
      pcnt_ff  <= pcnt_in;
      ncnt_ff  <= ncnt_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem[head.addr];
      end
   end

   assign clearing           = (state_ff == ST_CLEAR);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.cell_empty     = empty_ff;
   assign rsp.height_value   = value_ff;
   assign rsp.positive_count = pcnt_ff;
   assign rsp.negative_count = ncnt_ff;

endmodule

[rtl/signed_distance_cell_vote_map_top.sv]
// Signed-distance cell vote map.
// Transactions arrive on the request channel (req_chan) with a valid/ready
// handshake. Opcode 0 adds a distance sample to the cell chosen by its (u,v)
// coordinate, opcode 1 reads the cell given by cell_col and cell_row, and
// opcode 2 clears that cell. Only a read produces a response transaction on
// rsp_chan; opcode 3 is accepted and dropped. The grid size is to be written
// through the csr_ port only while the block is idle; the block itself does not
// enforce it. Index 0 is the width, index 1 the height. The front stage bins the
// coordinate and pushes the work into a two-entry queue. The back stage does a
// read-modify-write of one cell word in the cell memory: it reads the memory in
// the fetch state, then updates it or loads the response register in the update
// state, and takes the next transaction from the queue only when it is through
// with the last. After reset the back stage sweeps all 4096 cell words, one per
// cycle, and req_chan.ready stays low until the sweep is done. Grid sizes reset
// to 64. When the response receiver stalls, the finished read waits in the output
// register; the back stage holds the next read, and the queue keeps taking
// requests until it fills, after which req_chan.ready drops.
`include "signed_distance_cell_vote_map_top_macros.svh"

module signed_distance_cell_vote_map_top import sdcvm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   sdcvm_req_if.sink                  req_chan,
   sdcvm_rsp_if.source                rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata
);

   // Handshake between the front stage, the queue and the back stage.
   logic              push;
   logic              pop;
   logic              clearing;
   entry_type         push_entry;
   entry_type         head;
   queue_status_type  q_stat;

   // The front stage holds the grid size registers and bins samples.
   sdcvm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .clearing   (clearing),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   // The queue lets the front keep accepting while the back is busy.
   sdcvm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   // The back stage owns the cell memory and the response register.
   sdcvm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_stat   (q_stat),
      .pop      (pop),
      .clearing (clearing),
      .rsp      (rsp_chan)
   );

   // No request may be taken while the memory sweep is still running.
   `SDCVM_ASSERT_SAME(a_no_accept_in_sweep, clock, reset,
      req_chan.valid && req_chan.ready, !clearing, "request accepted during sweep")
   // The front never pushes into a full queue.
   `SDCVM_ASSERT_SAME(a_no_push_full, clock, reset, push, !q_stat.full,
      "push into full queue")
   // The back never pops an empty queue.
   `SDCVM_ASSERT_SAME(a_no_pop_empty, clock, reset, pop, !q_stat.empty,
      "pop from empty queue")
   // A push without a pop always leaves work queued.
   `SDCVM_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, !q_stat.empty,
      "queue empty after push")

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import sdcvm_pkg::*;

   // The opcode field has a fourth code that the block accepts and drops.
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   // One request transaction as the sender drives it. The opcode is kept as a
   // plain vector so that the unused code can be sent as well.
   typedef struct {
      logic [OP_BITS-1:0]          opcode;
      logic signed [DIST_BITS-1:0] distance;
      logic [COORD_BITS-1:0]       coord_u;
      logic [COORD_BITS-1:0]       coord_v;
      logic [CELL_BITS-1:0]        cell_col;
      logic [CELL_BITS-1:0]        cell_row;
   } vote_request;

   // What a read of one cell returns.
   typedef struct {
      logic                        cell_empty;
      logic signed [DIST_BITS-1:0] height_value;
      logic [CNT_BITS-1:0]         positive_count;
      logic [CNT_BITS-1:0]         negative_count;
   } cell_reading;

   // Mirror of the cell memory and the grid size registers. Every accepted
   // request is applied to the mirror; every read leaves the reading it must
   // produce in a queue, and responses are checked against that queue in order.
   class cell_vote_board;
      logic [CNT_BITS-1:0]         pos_votes[CELL_COUNT];
      logic [CNT_BITS-1:0]         neg_votes[CELL_COUNT];
      logic signed [DIST_BITS-1:0] top_dist[CELL_COUNT];
      logic signed [DIST_BITS-1:0] bottom_dist[CELL_COUNT];
      logic [SIZE_BITS-1:0]        width_reg;
      logic [SIZE_BITS-1:0]        height_reg;
      cell_reading                 pending_readings[$];
      int                          errors;

      function new();
         width_reg  = SIZE_RESET;
         height_reg = SIZE_RESET;
         errors     = 0;
         for (int a = 0; a < CELL_COUNT; a++) begin
            wipe_cell(a);
         end
      endfunction

      function void wipe_cell(int a);
         pos_votes[a]   = '0;
         neg_votes[a]   = '0;
         top_dist[a]    = DIST_MIN;
         bottom_dist[a] = DIST_MAX;
      endfunction

      // A size of zero acts as one column or row; anything past the grid acts
      // as the whole grid.
      function int unsigned size_in_use(logic [SIZE_BITS-1:0] v, int unsigned top);
         if (v == 0) begin
            return 1;
         end
         return (v > top) ? top : v;
      endfunction

      function logic [CELL_BITS-1:0] bin_index(logic [COORD_BITS-1:0] coord,
                                              int unsigned size);
         int unsigned c;
         int unsigned b;
         c = (coord > COORD_ONE) ? COORD_ONE : coord;
         b = (c * size) >> FRAC_BITS;
         if (b >= size) begin
            b = size - 1;
         end
         return b[CELL_BITS-1:0];
      endfunction

      function void set_grid(logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h);
         width_reg  = w;
         height_reg = h;
      endfunction

      function int pending();
         return pending_readings.size();
      endfunction

      function void apply_request(vote_request r);
         int          a;
         cell_reading rd;
         case (r.opcode)
            OP_ADD: begin
               a = int'(bin_index(r.coord_v, size_in_use(height_reg, MAX_ROWS))) * MAX_COLS
                   + int'(bin_index(r.coord_u, size_in_use(width_reg, MAX_COLS)));
               if (r.distance < 0) begin
                  if (neg_votes[a] != CNT_MAX) neg_votes[a]++;
               end else begin
                  if (pos_votes[a] != CNT_MAX) pos_votes[a]++;
               end
               if (r.distance > top_dist[a]) top_dist[a] = r.distance;
               if (r.distance < bottom_dist[a]) bottom_dist[a] = r.distance;
            end
            OP_READ: begin
               // The cell fields are only six bits wide, so every addressed
               // cell lies within the stored grid.
               a = int'(r.cell_row) * MAX_COLS + int'(r.cell_col);
               rd.positive_count = pos_votes[a];
               rd.negative_count = neg_votes[a];
               rd.cell_empty     = (pos_votes[a] == 0) && (neg_votes[a] == 0);
               if (rd.cell_empty) begin
                  rd.height_value = '0;
               end else if (pos_votes[a] > neg_votes[a]) begin
                  rd.height_value = top_dist[a];
               end else begin
                  rd.height_value = bottom_dist[a];
               end
               pending_readings.push_back(rd);
            end
            OP_CLEAR: begin
               wipe_cell(int'(r.cell_row) * MAX_COLS + int'(r.cell_col));
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_field(string name, int expected_v, int actual_v);
         if (expected_v != actual_v) begin
            $display("%0t ns: %s differs, expected %0d, actual %0d",
                     $time, name, expected_v, actual_v);
            errors++;
         end
      endfunction

      function void check_reading(cell_reading got);
         cell_reading want;
         if (pending_readings.size() == 0) begin
            $display("%0t ns: extra response, expected none, actual %0b %0d %0d %0d",
                     $time, got.cell_empty, got.height_value,
                     got.positive_count, got.negative_count);
            errors++;
            return;
         end
         want = pending_readings.pop_front();
         compare_field("cell_empty", want.cell_empty, got.cell_empty);
         compare_field("height_value", int'(want.height_value), int'(got.height_value));
         compare_field("positive_count", want.positive_count, got.positive_count);
         compare_field("negative_count", want.negative_count, got.negative_count);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   sdcvm_req_if req_chan();
   sdcvm_rsp_if rsp_chan();

   signed_distance_cell_vote_map_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cell_vote_board board = new();

   // Largest idle gap, in cycles, that the sender and the receiver draw for
   // each transaction. Zero gives stretches with no idling at all.
   int send_top = 0;
   int recv_top = 0;
   // Set by the stimulus to make the receiver hold off for a long stretch.
   bit hold_request = 1'b0;
   // Grid size in effect, used to aim reads and clears at cells that fill up.
   int unsigned cols_now = MAX_COLS;
   int unsigned rows_now = MAX_ROWS;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Both monitors sample at the rising edge, before the block updates, so the
   // predictor sees every handshake in the order the block does.
   always @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         board.apply_request('{req_chan.opcode, req_chan.distance, req_chan.coord_u,
                               req_chan.coord_v, req_chan.cell_col, req_chan.cell_row});
      end
   end

   always @(posedge clock) begin
      if (rsp_chan.valid && rsp_chan.ready) begin
         board.check_reading('{rsp_chan.cell_empty, rsp_chan.height_value,
                               rsp_chan.positive_count, rsp_chan.negative_count});
      end
   end

   // Response receiver. Before each transaction it lowers ready for a random
   // number of cycles. When the stimulus asks for it, the stall is a long one,
   // so that reads pile up in the block and the request side backs up.
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      forever begin
         stall = $urandom_range(0, recv_top);
         if (hold_request) begin
            stall        = 300;
            hold_request = 1'b0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   function automatic vote_request make_request(logic [OP_BITS-1:0] op,
                                                logic signed [DIST_BITS-1:0] sample_distance,
                                                logic [COORD_BITS-1:0] u,
                                                logic [COORD_BITS-1:0] v,
                                                logic [CELL_BITS-1:0] col,
                                                logic [CELL_BITS-1:0] row);
      vote_request r;
      r.opcode   = op;
      r.distance = sample_distance;
      r.coord_u  = u;
      r.coord_v  = v;
      r.cell_col = col;
      r.cell_row = row;
      return r;
   endfunction

   // Coordinates land on the edges of the unit range, past one, or anywhere
   // in between.
   function automatic logic [COORD_BITS-1:0] random_coord();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return COORD_ONE;
      if (pick == 2) return COORD_BITS'($urandom_range(65537, 131071));
      return COORD_BITS'($urandom_range(0, 65535));
   endfunction

   function automatic logic signed [DIST_BITS-1:0] random_distance();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return DIST_MIN;
      if (pick == 2) return DIST_MAX;
      if (pick == 3) return DIST_BITS'($urandom_range(0, 200) - 100);
      return DIST_BITS'($urandom);
   endfunction

   // Mostly samples and reads; reads and clears are usually aimed inside the
   // grid in use so they find cells that have been voted on.
   function automatic vote_request random_request();
      vote_request r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         r.opcode = OP_ADD;
      end else if (pick < 85) begin
         r.opcode = OP_READ;
      end else if (pick < 95) begin
         r.opcode = OP_CLEAR;
      end else begin
         r.opcode = OP_UNUSED;
      end
      r.distance = random_distance();
      r.coord_u  = random_coord();
      r.coord_v  = random_coord();
      if ($urandom_range(0, 3) != 0) begin
         r.cell_col = CELL_BITS'($urandom_range(0, cols_now - 1));
         r.cell_row = CELL_BITS'($urandom_range(0, rows_now - 1));
      end else begin
         r.cell_col = CELL_BITS'($urandom);
         r.cell_row = CELL_BITS'($urandom);
      end
      return r;
   endfunction

   // Offers one transaction and returns at the rising edge that accepts it.
   // Valid is left high, so a following transaction with no gap goes out
   // back to back; every change happens at a falling edge.
   task automatic send(input vote_request r);
      int gap;
      gap = $urandom_range(0, send_top);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.opcode   <= r.opcode;
      req_chan.distance <= r.distance;
      req_chan.coord_u  <= r.coord_u;
      req_chan.coord_v  <= r.coord_v;
      req_chan.cell_col <= r.cell_col;
      req_chan.cell_row <= r.cell_row;
      req_chan.valid    <= 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   // Waits until every read has been answered. Samples and clears give no
   // response and can still sit in the two-entry queue and the back stage, so
   // the task waits past the last response before the block counts as idle.
   task automatic wait_idle();
      stop_sending();
      while (board.pending() != 0) @(posedge clock);
      repeat (12) @(negedge clock);
   endtask

   // Writes the width register first and then the height register.
   task automatic set_grid(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAP_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_MAP_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.set_grid(w, h);
      cols_now = board.size_in_use(w, MAX_COLS);
      rows_now = board.size_in_use(h, MAX_ROWS);
   endtask

   // One random phase under one grid setting. Halfway through, the sender
   // pauses until every read has been answered.
   task automatic run_phase(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h,
                            input int count, input int s_top, input int r_top);
      wait_idle();
      set_grid(w, h);
      send_top = s_top;
      recv_top = r_top;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            wait_idle();
         end
         send(random_request());
      end
   endtask

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_MAP_WIDTH;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.opcode   = OP_ADD;
      req_chan.distance = '0;
      req_chan.coord_u  = '0;
      req_chan.coord_v  = '0;
      req_chan.cell_col = '0;
      req_chan.cell_row = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset grid of 64 by 64. The block sweeps its
      // memory first and holds off requests until it is done.
      send(make_request(OP_READ, '0, '0, '0, '0, '0));
      // A zero distance votes positive, the most negative one votes negative,
      // and the equal vote reads back the minimum.
      send(make_request(OP_ADD, '0, '0, '0, '0, '0));
      send(make_request(OP_ADD, DIST_MIN, '0, '0, '0, '0));
      send(make_request(OP_READ, '0, '0, '0, '0, '0));
      // Exactly one, past one, and just below one all land in the last cell.
      send(make_request(OP_ADD, DIST_MAX, COORD_ONE, COORD_ONE, '0, '0));
      send(make_request(OP_ADD, -24'sd1, 17'h1FFFF, 17'h1FFFF, '0, '0));
      send(make_request(OP_ADD, 24'sd5, 17'd65535, 17'd65535, '0, '0));
      send(make_request(OP_READ, '0, '0, '0, 6'd63, 6'd63));
      send(make_request(OP_CLEAR, '0, '0, '0, 6'd63, 6'd63));
      send(make_request(OP_READ, '0, '0, '0, 6'd63, 6'd63));
      // The unused opcode with every other field at its top must do nothing.
      send(make_request(OP_UNUSED, -24'sd1, 17'h1FFFF, 17'h1FFFF, 6'd63, 6'd63));
      send(make_request(OP_READ, '0, '0, '0, '0, '0));
      send(make_request(OP_CLEAR, '0, '0, '0, '0, '0));
      send(make_request(OP_READ, '0, '0, '0, '0, '0));
      send(make_request(OP_ADD, 24'sd1234, 17'd32768, 17'd1024, '0, '0));
      send(make_request(OP_READ, '0, '0, '0, 6'd32, 6'd1));
      send(make_request(OP_READ, '0, '0, '0, 6'd5, 6'd7));

      // Two positive votes against one negative one pick the maximum, and the
      // clear that follows empties the cell again.
      send(make_request(OP_ADD, 24'sd300, 17'd1024, 17'd0, '0, '0));
      send(make_request(OP_ADD, -24'sd7, 17'd1024, 17'd0, '0, '0));
      send(make_request(OP_ADD, 24'sd9, 17'd1024, 17'd0, '0, '0));
      send(make_request(OP_READ, '0, '0, '0, 6'd1, 6'd0));
      send(make_request(OP_CLEAR, '0, '0, '0, 6'd1, 6'd0));
      send(make_request(OP_READ, '0, '0, '0, 6'd1, 6'd0));

      // Random phases over a range of grid settings, including a size of zero,
      // the largest register value, and values past the grid.
      run_phase(7'd1, 7'd1, 150, 19, 19);
      run_phase(7'd0, 7'd0, 100, 5, 0);
      run_phase(7'd2, 7'd3, 250, 0, 0);
      run_phase(7'd127, 7'd127, 150, 19, 19);
      run_phase(7'd64, 7'd1, 150, 19, 5);
      run_phase(7'd5, 7'd64, 150, 3, 19);
      run_phase(7'd100, 7'd65, 100, 0, 19);

      // The receiver stalls for a long stretch while reads keep coming with
      // no gap, so the block fills and drops its request ready.
      run_phase(7'd3, 7'd3, 100, 19, 19);
      hold_request = 1'b1;
      send_top     = 0;
      repeat (40) begin
         send(make_request(OP_READ, '0, '0, '0, CELL_BITS'($urandom_range(0, 2)),
                           CELL_BITS'($urandom_range(0, 2))));
      end

      run_phase(7'd4, 7'd2, 250, 19, 19);
      run_phase(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)), 200, 10, 10);
      run_phase(7'd64, 7'd64, 50, 0, 0);

      stop_sending();
      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: ends a run that hangs.
   initial begin
      #5000000;
      $display("%0t ns: timeout", $time);
      $display("Mismatches found");
      $finish;
   end

endmodule
